### hdl/vn4_pkg.sv
// package: shared constants for the four-component vector normaliser
`default_nettype none
package vn4_pkg;
	localparam int COMP_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int NUM_COMPS      = 4;
endpackage
`default_nettype wire

### hdl/vector4_normalize.sv
// module: pipelined four-component fixed-point vector normaliser
`default_nettype none
// Scales a signed fixed-point 4-vector (x, y, z, w) to unit length. One transaction is
// accepted every cycle while the output side keeps up; results leave in input order
// through 4 stages for magnitude, squaring and summation, COMP_WIDTH + 1 stages of the
// bit-per-stage square root, FRAC_BITS + 1 stages of the four parallel bit-per-stage
// dividers, and the output register. The whole pipeline advances together and holds only
// while a result waits at the output with m_tready low. A zero vector gives zero
// components with zero_length set in m_tuser.
module vector4_normalize #(
	parameter int COMP_WIDTH = vn4_pkg::COMP_WIDTH_DEF,
	parameter int FRAC_BITS  = vn4_pkg::FRAC_BITS_DEF,
	parameter int IN_W       = ((vn4_pkg::NUM_COMPS * COMP_WIDTH + 7) / 8) * 8,
	parameter int OUT_W      = ((vn4_pkg::NUM_COMPS * (FRAC_BITS + 2) + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,  // comp_x, comp_y, comp_z, comp_w
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata,  // unit_x, unit_y, unit_z, unit_w
	output logic                  m_tuser   // zero_length
);
	localparam int NC   = vn4_pkg::NUM_COMPS;
	localparam int W    = COMP_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int UW   = F + 2;
	localparam int RW   = W + 1;
	localparam int SW   = 2 * RW;
	localparam int REMW = RW + 2;
	localparam int DRW  = W + 1;
	localparam int QW   = F + 1;

	logic en;

	// stage 1: magnitude and sign
	logic                 v_s1;
	logic [NC-1:0][W-1:0] mag_s1;
	logic [NC-1:0]        neg_s1;
	// stage 2: squares
	logic                   v_s2;
	logic [NC-1:0][2*W-1:0] sq_s2;
	logic [NC-1:0][W-1:0]   mag_s2;
	logic [NC-1:0]          neg_s2;
	// stage 3: pair sums
	logic                 v_s3;
	logic [1:0][2*W:0]    pair_s3;
	logic [NC-1:0][W-1:0] mag_s3;
	logic [NC-1:0]        neg_s3;
	// stage 4: full sum
	logic                 v_s4;
	logic [SW-1:0]        sum_s4;
	logic [NC-1:0][W-1:0] mag_s4;
	logic [NC-1:0]        neg_s4;

	// square root stages, index k is the input of step k
	logic                 rt_v   [0:RW];
	logic [SW-1:0]        rt_sum [0:RW];
	logic [REMW-1:0]      rt_rem [0:RW];
	logic [RW-1:0]        rt_root[0:RW];
	logic [NC-1:0][W-1:0] rt_mag [0:RW];
	logic [NC-1:0]        rt_neg [0:RW];

	// divider stages, index j is the input of step j
	logic                   dv_v  [0:QW];
	logic [RW-1:0]          dv_len[0:QW];
	logic [NC-1:0][DRW-1:0] dv_rem[0:QW];
	logic [NC-1:0][QW-1:0]  dv_q  [0:QW];
	logic [NC-1:0]          dv_b0 [0:QW];
	logic [NC-1:0]          dv_neg[0:QW];

	logic                  out_v_q;
	logic [NC-1:0][UW-1:0] unit_q;
	logic                  zero_q;

	assign en       = !out_v_q || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NC; i++) begin
				neg_s1[i] <= s_tdata[i*W + W - 1];
				mag_s1[i] <= s_tdata[i*W + W - 1] ? (W'(0) - s_tdata[i*W +: W])
				                                   : s_tdata[i*W +: W];
				sq_s2[i]  <= (2*W)'(mag_s1[i]) * (2*W)'(mag_s1[i]);
			end
			mag_s2     <= mag_s1;
			neg_s2     <= neg_s1;
			pair_s3[0] <= (2*W+1)'(sq_s2[0]) + (2*W+1)'(sq_s2[1]);
			pair_s3[1] <= (2*W+1)'(sq_s2[2]) + (2*W+1)'(sq_s2[3]);
			mag_s3     <= mag_s2;
			neg_s3     <= neg_s2;
			sum_s4     <= SW'(pair_s3[0]) + SW'(pair_s3[1]);
			mag_s4     <= mag_s3;
			neg_s4     <= neg_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign rt_v[0]    = v_s4;
	assign rt_sum[0]  = sum_s4;
	assign rt_rem[0]  = '0;
	assign rt_root[0] = '0;
	assign rt_mag[0]  = mag_s4;
	assign rt_neg[0]  = neg_s4;

	for (genvar k = 0; k < RW; k++) begin : g_root
		logic [REMW+1:0] cur;
		logic [REMW+1:0] trial;
		logic            fits;

		assign cur   = {rt_rem[k], rt_sum[k][SW-1-2*k -: 2]};
		assign trial = {2'b00, rt_root[k], 2'b01};
		assign fits  = cur >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rt_sum[k+1]  <= rt_sum[k];
				rt_mag[k+1]  <= rt_mag[k];
				rt_neg[k+1]  <= rt_neg[k];
				rt_rem[k+1]  <= fits ? REMW'(cur - trial) : REMW'(cur);
				rt_root[k+1] <= {rt_root[k][RW-2:0], fits};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v[k+1] <= 1'b0;
			end else if (en) begin
				rt_v[k+1] <= rt_v[k];
			end
		end
	end

	assign dv_v[0]   = rt_v[RW];
	assign dv_len[0] = rt_root[RW];
	assign dv_neg[0] = rt_neg[RW];
	for (genvar i = 0; i < NC; i++) begin : g_dinit
		assign dv_rem[0][i] = DRW'(rt_mag[RW][i] >> 1);
		assign dv_q[0][i]   = '0;
		assign dv_b0[0][i]  = rt_mag[RW][i][0];
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		for (genvar i = 0; i < NC; i++) begin : g_lane
			logic [DRW:0] cur;
			logic         fits;

			assign cur  = {dv_rem[j][i], (j == 0) ? dv_b0[j][i] : 1'b0};
			assign fits = cur >= (DRW+1)'(dv_len[j]);

			always_ff @(posedge clk) begin
				if (en) begin
					dv_rem[j+1][i] <= fits ? DRW'(cur - (DRW+1)'(dv_len[j])) : DRW'(cur);
					dv_q[j+1][i]   <= {dv_q[j][i][QW-2:0], fits};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_len[j+1] <= dv_len[j];
				dv_neg[j+1] <= dv_neg[j];
				dv_b0[j+1]  <= dv_b0[j];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j+1] <= 1'b0;
			end else if (en) begin
				dv_v[j+1] <= dv_v[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_q <= dv_len[QW] == '0;
			for (int i = 0; i < NC; i++) begin
				if (dv_len[QW] == '0) begin
					unit_q[i] <= '0;
				end else if (dv_neg[QW][i]) begin
					unit_q[i] <= UW'(0) - UW'(dv_q[QW][i]);
				end else begin
					unit_q[i] <= UW'(dv_q[QW][i]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dv_v[QW];
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = OUT_W'(unit_q);
	assign m_tuser  = zero_q;

`ifndef ASSERT_OFF
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");
	a_zero_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (unit_q == '0))
		else $error("zero vector with nonzero components");
	a_nonzero_has_component: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (unit_q != '0))
		else $error("nonzero vector normalised to all zero");
	a_valid_moves_on_enable: assert property (@(posedge clk) disable iff (!arst_n)
		(!en) |=> (m_tvalid == $past(m_tvalid)))
		else $error("output valid changed during stall");
`endif
endmodule
`default_nettype wire

### dv/vector4_normalize_tb.sv
// testbench: stream checks of the four-component vector normaliser against its own predictor
`timescale 1ns / 1ps
module vector4_normalize_tb;
	localparam int NUM_COMPS = vn4_pkg::NUM_COMPS;
	localparam int CW = vn4_pkg::COMP_WIDTH_DEF;
	localparam int FB = vn4_pkg::FRAC_BITS_DEF;
	localparam int UW = FB + 2;
	localparam int IN_W = ((NUM_COMPS * CW + 7) / 8) * 8;
	localparam int OUT_W = ((NUM_COMPS * UW + 7) / 8) * 8;
	localparam int LATENCY = CW + FB + 7;
	localparam int N_RANDOM = 1030;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [UW-1:0] w;
		logic [UW-1:0] z;
		logic [UW-1:0] y;
		logic [UW-1:0] x;
	} units_t;

	typedef struct {
		units_t u;
		logic zl;
	} unit_vec_t;

	typedef struct {
		logic [CW-1:0] c[NUM_COMPS];
		logic known;
		unit_vec_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic m_tuser;

	unit_vec_t unit_queue[$];
	int errors = 0;
	int results_seen = 0;
	int zero_seen = 0;
	longint cycles = 0;
	bit long_hold = 1'b0;
	bit hold_done = 1'b0;

	vector4_normalize dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [32:0] floor_root(logic [64:0] s);
		logic [32:0] r;
		logic [32:0] cand;
		logic [65:0] sq;
		r = '0;
		for (int b = 32; b >= 0; b--) begin
			cand = r | (33'd1 << b);
			if (cand <= 33'h1_0000_0000) begin
				sq = 66'(cand) * 66'(cand);
				if (sq <= 66'(s))
					r = cand;
			end
		end
		return r;
	endfunction

	function automatic unit_vec_t normalise(logic [CW-1:0] c[NUM_COMPS]);
		unit_vec_t o;
		logic [CW:0] mag[NUM_COMPS];
		logic [64:0] sum;
		logic [32:0] len;
		logic [UW-1:0] q[NUM_COMPS];
		logic [64:0] num;
		sum = '0;
		for (int i = 0; i < NUM_COMPS; i++) begin
			mag[i] = c[i][CW-1] ? (CW+1)'(-$signed({c[i][CW-1], c[i]})) : {1'b0, c[i]};
			sum += 65'(mag[i]) * 65'(mag[i]);
		end
		len = floor_root(sum);
		o.zl = (len == 0);
		for (int i = 0; i < NUM_COMPS; i++) begin
			if (len == 0)
				q[i] = '0;
			else begin
				num = 65'(mag[i]) << FB;
				q[i] = UW'(num / 65'(len));
				if (c[i][CW-1])
					q[i] = -q[i];
			end
		end
		o.u = {q[3], q[2], q[1], q[0]};
		return o;
	endfunction

	task automatic send_vector(logic [CW-1:0] c[NUM_COMPS]);
		s_tdata <= {c[3], c[2], c[1], c[0]};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic random_vector(output logic [CW-1:0] c[NUM_COMPS]);
		int mode;
		mode = $urandom_range(0, 5);
		for (int i = 0; i < NUM_COMPS; i++) begin
			case (mode)
				0: c[i] = $urandom;
				1: c[i] = CW'($signed($urandom_range(0, 255)) - 128);
				2: c[i] = ($urandom_range(0, 1)) ? '0 : CW'($urandom);
				3: c[i] = $urandom_range(0, 1) ? {1'b1, {(CW-1){1'b0}}} : CW'($urandom);
				default: c[i] = CW'($signed($urandom) >>> $urandom_range(0, 31));
			endcase
		end
	endtask

	// prediction at input acceptance
	always @(posedge clk) begin
		logic [CW-1:0] c[NUM_COMPS];
		if (arst_n && s_tvalid && s_tready) begin
			for (int i = 0; i < NUM_COMPS; i++)
				c[i] = s_tdata[i*CW +: CW];
			unit_queue.push_back(normalise(c));
		end
	end

	// result checking
	always @(posedge clk) begin
		unit_vec_t e;
		units_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[NUM_COMPS*UW-1:0];
			results_seen++;
			if (m_tuser)
				zero_seen++;
			if (unit_queue.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction, actual %h/%b", $time, got, m_tuser);
			end else begin
				e = unit_queue.pop_front();
				if (got.x !== e.u.x || got.y !== e.u.y || got.z !== e.u.z || got.w !== e.u.w
						|| m_tuser !== e.zl) begin
					errors++;
					$display("%0t: mismatch, expected %h/%b, actual %h/%b",
						$time, e.u, e.zl, got, m_tuser);
				end
			end
		end
	end

	// receiver stall pattern, with one long hold-off
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else if (long_hold && !hold_done) begin
			m_tready <= 1'b0;
			repeat (3 * LATENCY) @(posedge clk);
			hold_done <= 1'b1;
			m_tready <= 1'b1;
		end else if (cycles % 600 < 150)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	localparam logic [CW-1:0] MAXP = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] MINN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [CW-1:0] ONE = CW'(1) << FB;
	localparam logic [UW-1:0] U_ONE = UW'(1) << FB;
	localparam logic [UW-1:0] U_MONE = -(UW'(1) << FB);

	stim_row_t rows[$];

	task automatic add_row(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
			logic [CW-1:0] w, logic known, units_t u, logic zl);
		stim_row_t r;
		r.c[0] = x; r.c[1] = y; r.c[2] = z; r.c[3] = w;
		r.known = known; r.res.u = u; r.res.zl = zl;
		rows.push_back(r);
	endtask

	initial begin
		logic [CW-1:0] c[NUM_COMPS];
		unit_vec_t p;
		int sent;
		int burst;
		add_row('0, '0, '0, '0, 1'b1, '0, 1'b1);
		add_row(ONE, '0, '0, '0, 1'b1, {UW'(0), UW'(0), UW'(0), U_ONE}, 1'b0);
		add_row('0, -ONE, '0, '0, 1'b1, {UW'(0), UW'(0), U_MONE, UW'(0)}, 1'b0);
		add_row('0, '0, MAXP, '0, 1'b1, {UW'(0), U_ONE, UW'(0), UW'(0)}, 1'b0);
		add_row('0, '0, '0, MINN, 1'b1, {U_MONE, UW'(0), UW'(0), UW'(0)}, 1'b0);
		add_row(CW'(1), '0, '0, '0, 1'b1, {UW'(0), UW'(0), UW'(0), U_ONE}, 1'b0);
		add_row('1, '0, '0, '0, 1'b1, {UW'(0), UW'(0), UW'(0), U_MONE}, 1'b0);
		add_row(MINN, MINN, MINN, MINN, 1'b0, '0, 1'b0);
		add_row(MAXP, MAXP, MAXP, MAXP, 1'b0, '0, 1'b0);
		add_row(MAXP, MINN, MAXP, MINN, 1'b0, '0, 1'b0);
		add_row(ONE, ONE, ONE, ONE, 1'b0, '0, 1'b0);
		add_row(CW'(1), '1, CW'(1), '1, 1'b0, '0, 1'b0);
		add_row(CW'(3), CW'(4), '0, '0, 1'b0, '0, 1'b0);
		add_row(CW'(32'h5555_5555), CW'(32'hAAAA_AAAA), CW'(7), '1, 1'b0, '0, 1'b0);
		add_row(CW'(32'h0001_8000), -ONE, CW'(32'h7FFF), MINN, 1'b0, '0, 1'b0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].known) begin
				p = normalise(rows[i].c);
				if (p.u !== rows[i].res.u || p.zl !== rows[i].res.zl) begin
					errors++;
					$display("%0t: table row %0d, expected %h/%b, actual %h/%b", $time, i,
						rows[i].res.u, rows[i].res.zl, p.u, p.zl);
				end
			end
			send_vector(rows[i].c);
		end
		s_tvalid <= 1'b0;
		// sender pauses until the pipe has drained
		while (unit_queue.size() != 0) @(posedge clk);

		sent = 0;
		while (sent < N_RANDOM) begin
			burst = $urandom_range(1, 40);
			if (sent >= 200 && !long_hold)
				long_hold <= 1'b1;
			for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
				random_vector(c);
				send_vector(c);
				sent++;
			end
			if ($urandom_range(0, 2) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;
		while (unit_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("covered %0d vectors, %0d zero-length, directed extremes and long back-pressure",
			rows.size() + N_RANDOM, zero_seen);
		$display("results checked: %0d, errors: %0d", results_seen, errors);
		if (errors == 0 && unit_queue.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
